/* rtl/assert_macros.svh */
// assertion macros for the checker file of this block
// no dependencies; take in with `include "assert_macros.svh"
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property sampled on the rising clock, off while reset is low
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// implication from one cycle into the next
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  `ASSERT_CLK(name, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/ggt_pkg.sv */
// shared types and constants of the byte-serial ghash tag block
// no dependencies; used by ggt_datapath, ggt_ctrl, gcm_ghash_tag and ggt_checker
package ggt_pkg;

  localparam int unsigned BlkW    = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned TotalW  = 61;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CntW    = 7;
  localparam int unsigned CfgIdxW = 2;

  // gcm reduction polynomial, top byte of the field constant
  localparam logic [7:0] GfReduce = 8'hE1;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_ABSORB = 2'd0,
    FUNC_TAG    = 2'd1,
    FUNC_J0     = 2'd2,
    FUNC_NONE   = 2'd3
  } ggt_func_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HI  = 2'd0,
    CFG_KEY_LO  = 2'd1,
    CFG_MASK_HI = 2'd2,
    CFG_MASK_LO = 2'd3
  } ggt_cfg_e;

  // controller to datapath commands
  typedef struct packed {
    logic absorb;
    logic mul_init;
    logic mul_step;
    logic fold_len;
    logic fold_hi;
    logic load_out;
    logic use_mask;
  } ggt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_zero;
    logic pos_last;
    logic mul_done;
    logic out_empty;
  } ggt_sts_t;

endpackage

/* rtl/gcm_ghash_tag.sv */
// Byte-serial GCM GHASH tag engine. Data bytes are taken one per beat; the sixteenth byte
// of a block starts a bit-serial GF(2^128) multiply by H that handles one key bit per
// cycle, and no beat is taken until it is done. A finish beat (tag or J0) closes the
// message: if a partial block is open, the zero-padded block is multiplied and then the
// length block is folded in; otherwise the length block is folded in the cycle the beat
// is taken. Then come the final multiply and the load of the result into the output
// buffer. That load waits while beats of the previous result are still in the buffer.
// The buffer presents the result as two 64-bit beats, upper half first. The next item is
// accepted as soon as the load is done, while the result beats still wait. The single
// shared multiplier serves data blocks and finishes alike. Configuration writes take
// effect at once and may come at any time the engine is idle.
// depends on ggt_pkg, ggt_ctrl and ggt_datapath
module gcm_ghash_tag (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]                  s_axis_tuser_i,  // [1:0] func
  // result beats
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [ggt_pkg::HalfW-1:0]   m_axis_tdata_o,  // [63:0] tag_half
  output logic                        m_axis_tlast_o,  // last_half
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [ggt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ggt_pkg::HalfW-1:0]   cfg_wdata_i
);
  import ggt_pkg::*;

  ggt_cmd_t cmd;
  ggt_sts_t sts;

  // sequencer
  ggt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .func_i     (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hash datapath
  ggt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

/* rtl/ggt_datapath.sv */
// ghash datapath: configuration registers, accumulator, counters, bit-serial gf(2^128) multiplier, result buffer
// depends on ggt_pkg
module ggt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ggt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ggt_pkg::HalfW-1:0]     cfg_wdata_i,
  input  logic [7:0]                    data_byte_i,
  input  ggt_pkg::ggt_cmd_t             cmd_i,
  output ggt_pkg::ggt_sts_t             sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [ggt_pkg::HalfW-1:0]     m_tdata_o,
  output logic                          m_tlast_o
);
  import ggt_pkg::*;

  localparam logic [BlkW-1:0] RedPoly = {GfReduce, {(BlkW-8){1'b0}}};
  localparam logic [CntW-1:0] CntLast = CntW'(BlkW - 1);

  logic [HalfW-1:0]  key_hi_q, key_lo_q, mask_hi_q, mask_lo_q;
  logic [BlkW-1:0]   acc_q, acc_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [BlkW-1:0]   z_q, z_d, y_q, y_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [HalfW-1:0]  out_hi_q, out_hi_d, out_lo_q, out_lo_d;
  logic [1:0]        out_cnt_q, out_cnt_d;
  logic [BlkW-1:0]   z_nxt, v_nxt;
  logic [HalfW-1:0]  bit_len;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      mask_hi_q <= '0;
      mask_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ggt_cfg_e'(cfg_idx_i))
        CFG_KEY_HI:  key_hi_q  <= cfg_wdata_i;
        CFG_KEY_LO:  key_lo_q  <= cfg_wdata_i;
        CFG_MASK_HI: mask_hi_q <= cfg_wdata_i;
        CFG_MASK_LO: mask_lo_q <= cfg_wdata_i;
      endcase
    end
  end

  // one multiplier iteration: z accumulates v, v is multiplied by x mod p
  assign z_nxt   = z_q ^ (y_q[BlkW-1] ? acc_q : '0);
  assign v_nxt   = {1'b0, acc_q[BlkW-1:1]} ^ (acc_q[0] ? RedPoly : '0);
  assign bit_len = {total_q, 3'b000};

  // accumulator, counters, multiplier and output buffer registers
  always_comb begin
    acc_d     = acc_q;
    pos_d     = pos_q;
    total_d   = total_q;
    z_d       = z_q;
    y_d       = y_q;
    cnt_d     = cnt_q;
    out_hi_d  = out_hi_q;
    out_lo_d  = out_lo_q;
    out_cnt_d = out_cnt_q;
    // absorb a byte at the current big-endian position
    if (cmd_i.absorb) begin
      for (int i = 0; i < 16; i++) begin
        if (pos_q == PosW'(i)) begin
          acc_d[BlkW-1-8*i -: 8] = acc_q[BlkW-1-8*i -: 8] ^ data_byte_i;
        end
      end
      pos_d   = pos_q + PosW'(1);
      total_d = total_q + TotalW'(1);
    end
    // fold the length block into one half
    if (cmd_i.fold_len) begin
      if (cmd_i.fold_hi) begin
        acc_d[BlkW-1:HalfW] = acc_q[BlkW-1:HalfW] ^ bit_len;
      end else begin
        acc_d[HalfW-1:0] = acc_q[HalfW-1:0] ^ bit_len;
      end
    end
    // start a multiply
    if (cmd_i.mul_init) begin
      z_d   = '0;
      y_d   = {key_hi_q, key_lo_q};
      cnt_d = '0;
    end
    // multiplier step, the product lands in the accumulator on the last bit
    if (cmd_i.mul_step) begin
      z_d   = z_nxt;
      y_d   = {y_q[BlkW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      acc_d = (cnt_q == CntLast) ? z_nxt : v_nxt;
    end
    // hand the result to the output buffer and start over
    if (cmd_i.load_out) begin
      out_hi_d  = acc_q[BlkW-1:HalfW] ^ (cmd_i.use_mask ? mask_hi_q : '0);
      out_lo_d  = acc_q[HalfW-1:0] ^ (cmd_i.use_mask ? mask_lo_q : '0);
      out_cnt_d = 2'd2;
      acc_d     = '0;
      pos_d     = '0;
      total_d   = '0;
    end else if (m_tvalid_o && m_tready_i) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pos_q     <= '0;
      total_q   <= '0;
      cnt_q     <= '0;
      out_cnt_q <= '0;
    end else begin
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      total_q   <= total_d;
      cnt_q     <= cnt_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    z_q      <= z_d;
    y_q      <= y_d;
    out_hi_q <= out_hi_d;
    out_lo_q <= out_lo_d;
  end

  // result beats: upper half first
  assign m_tvalid_o = (out_cnt_q != 2'd0);
  assign m_tlast_o  = (out_cnt_q == 2'd1);
  assign m_tdata_o  = (out_cnt_q == 2'd2) ? out_hi_q : out_lo_q;

  // status
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.pos_last  = (pos_q == '1);
  assign sts_o.mul_done  = (cnt_q == CntLast);
  assign sts_o.out_empty = (out_cnt_q == 2'd0);

endmodule

/* rtl/ggt_ctrl.sv */
// ghash controller: sequences absorb, block multiply, finish and result load
// depends on ggt_pkg
module ggt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [1:0]        func_i,
  input  ggt_pkg::ggt_sts_t sts_i,
  output ggt_pkg::ggt_cmd_t cmd_o
);
  import ggt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_BLK = 6'b000010,
    ST_MUL_PAD = 6'b000100,
    ST_FOLD    = 6'b001000,
    ST_MUL_LEN = 6'b010000,
    ST_OUT     = 6'b100000
  } ggt_state_e;

  ggt_state_e state_q, state_d;
  logic       tag_q, tag_d;
  ggt_func_e  func;

  assign func       = ggt_func_e'(func_i);
  assign s_tready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    tag_d   = tag_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          unique case (func)
            FUNC_ABSORB: begin
              cmd_o.absorb = 1'b1;
              if (sts_i.pos_last) begin
                cmd_o.mul_init = 1'b1;
                state_d        = ST_MUL_BLK;
              end
            end
            FUNC_TAG, FUNC_J0: begin
              tag_d          = (func == FUNC_TAG);
              cmd_o.mul_init = 1'b1;
              if (!sts_i.pos_zero) begin
                state_d = ST_MUL_PAD;
              end else begin
                cmd_o.fold_len = 1'b1;
                cmd_o.fold_hi  = (func == FUNC_TAG);
                state_d        = ST_MUL_LEN;
              end
            end
            FUNC_NONE: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL_BLK: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_IDLE;
      end
      ST_MUL_PAD: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold_len = 1'b1;
        cmd_o.fold_hi  = tag_q;
        cmd_o.mul_init = 1'b1;
        state_d        = ST_MUL_LEN;
      end
      ST_MUL_LEN: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_empty) begin
          cmd_o.load_out = 1'b1;
          cmd_o.use_mask = tag_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tag_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
    end
  end

endmodule

/* rtl/ggt_checker.sv */
// port-level checks of gcm_ghash_tag and the bind that attaches them
// depends on ggt_pkg and assert_macros.svh
`include "assert_macros.svh"

module ggt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [1:0]                s_axis_tuser_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ggt_pkg::HalfW-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);
  import ggt_pkg::*;

  logic in_fin;
  logic out_beat;

  assign in_fin   = s_axis_tvalid_i && s_axis_tready_o &&
                    (s_axis_tuser_i == FUNC_TAG || s_axis_tuser_i == FUNC_J0);
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // a stalled result beat holds its payload
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  // an upper half is always followed at once by its lower half
  `ASSERT_NEXT(a_hi_then_lo, clk_i, rst_ni, out_beat && !m_axis_tlast_o,
    m_axis_tvalid_o && m_axis_tlast_o)
  // the buffer is empty right after a lower half leaves
  `ASSERT_NEXT(a_lo_drains, clk_i, rst_ni, out_beat && m_axis_tlast_o, !m_axis_tvalid_o)
  // a taken finish closes the input as the multiplier starts
  `ASSERT_NEXT(a_fin_busy, clk_i, rst_ni, in_fin, !s_axis_tready_o)

endmodule

bind gcm_ghash_tag ggt_checker u_ggt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
